FILE: rtl/core/nnis_pkg.sv
`timescale 1ns / 1ps

package nnis_pkg;

	// Configuration register map
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SCALE      = 2'd2;

	localparam int DIM_W  = 8;
	localparam int FACT_W = 16;
	localparam int FRAC_BITS = 8;
	localparam logic [DIM_W-1:0]  RST_SRC_WIDTH  = 8'd128;
	localparam logic [DIM_W-1:0]  RST_SRC_HEIGHT = 8'd128;
	localparam logic [FACT_W-1:0] RST_SCALE      = 16'd256;

	// Item opcodes, carried in the slave-side tuser
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam int CHAN_W  = 16;
	localparam int COORD_W = 15;
	localparam logic [COORD_W-1:0] COORD_MAX = '1;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 96;

	// Divider: coordinate << FRAC_BITS over the factor, two quotient bits per step
	localparam int DIVD_W    = 24;
	localparam int DIV_STEPS = DIVD_W / 2;

	typedef struct packed {
		logic load_wr;
		logic chk;
		logic div_start;
		logic div_row;
		logic cap_x;
		logic cap_y;
		logic mul;
		logic rd;
		logic out_load;
		logic out_empty;
		logic advance;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic div_done;
	} dp_sts_t;

endpackage

FILE: rtl/core/nnis_ram.sv
`timescale 1ns / 1ps

module nnis_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/nnis_div.sv
`timescale 1ns / 1ps

module nnis_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [nnis_pkg::DIVD_W-1:0] dividend,
	input  logic [nnis_pkg::FACT_W-1:0] divisor,
	output logic [nnis_pkg::DIVD_W-1:0] quotient,
	output logic                       done
);

	import nnis_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

	logic [FACT_W-1:0] rem_q;
	logic [DIVD_W-1:0] num_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [FACT_W:0]   r1, r1s, r2, r2s;
	logic              ge1, ge2;

	// Two restoring steps per cycle
	always_comb begin
		r1  = {rem_q, num_q[DIVD_W-1]};
		ge1 = r1 >= {1'b0, divisor};
		r1s = ge1 ? r1 - {1'b0, divisor} : r1;
		r2  = {r1s[FACT_W-1:0], num_q[DIVD_W-2]};
		ge2 = r2 >= {1'b0, divisor};
		r2s = ge2 ? r2 - {1'b0, divisor} : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Quotient bits shift in below the dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIVD_W-3:0], ge1, ge2};
			rem_q <= r2s[FACT_W-1:0];
		end
	end

	assign quotient = num_q;
	assign done     = done_q;

endmodule

FILE: rtl/core/nnis_dp.sv
`timescale 1ns / 1ps

module nnis_dp #(
	parameter int MAX_WIDTH    = 128,
	parameter int MAX_HEIGHT   = 128,
	parameter int CHANNEL_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nnis_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [nnis_pkg::IN_DATA_W-1:0]  in_data,
	input  nnis_pkg::dp_cmd_t              cmd,
	output nnis_pkg::dp_sts_t              sts,
	output logic [nnis_pkg::OUT_DATA_W-1:0] out_data,
	output logic                           out_last,
	output logic                           out_empty
);

	import nnis_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int SAT_W = AW + 1;
	localparam int PW    = SAT_W + DIM_W;
	localparam int SW    = PW + 1;
	localparam int LW    = (AW + 1 > 2 * DIM_W) ? AW + 1 : 2 * DIM_W;
	localparam int MEM_W = 4 * CHANNEL_BITS;
	localparam int SZ_W  = 2 * DIM_W;
	localparam int WP_W  = DIM_W + FACT_W;
	localparam logic [DIVD_W-1:0] SAT_MAX = DIVD_W'({SAT_W{1'b1}});
	localparam logic [SW-1:0]     DEPTH_V = SW'(DEPTH);

	logic [DIM_W-1:0]   src_width_q, src_height_q;
	logic [FACT_W-1:0]  factor_q;
	logic [COORD_W-1:0] ow_q, oh_q;
	logic [AW-1:0]      load_pos_q;
	logic [COORD_W-1:0] col_q, row_q;
	logic [SAT_W-1:0]   sx_q, sy_q;
	logic [PW-1:0]      prod_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic               out_last_q, out_empty_q;

	logic                 cfg_hit;
	logic [DIM_W-1:0]     w_eff, h_eff;
	logic [SZ_W-1:0]      size;
	logic [WP_W-1:0]      wprod, hprod;
	logic [FACT_W-1:0]    ow_raw, oh_raw;
	logic [COORD_W-1:0]   ow_next, oh_next;
	logic [LW-1:0]        pos_inc;
	logic                 load_wrap;
	logic                 coord_wrap;
	logic [COORD_W-1:0]   col_eff, row_eff;
	logic [DIVD_W-1:0]    dividend, quotient;
	logic                 div_done;
	logic [SAT_W-1:0]     quo_sat;
	logic [SW-1:0]        idx;
	logic [AW-1:0]        raddr;
	logic [MEM_W-1:0]     wdata, rdata;
	logic [4*CHAN_W-1:0]  pix;
	logic                 is_last;

	assign cfg_hit = cfg_we && (cfg_addr == REG_SRC_WIDTH || cfg_addr == REG_SRC_HEIGHT ||
		cfg_addr == REG_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RST_SRC_WIDTH;
			src_height_q <= RST_SRC_HEIGHT;
			factor_q     <= RST_SCALE;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SRC_WIDTH:  src_width_q  <= cfg_wdata[DIM_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_wdata[DIM_W-1:0];
				REG_SCALE:      factor_q     <= cfg_wdata[FACT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp to store size, derive output size
	always_comb begin
		w_eff = (int'(src_width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : src_width_q;
		h_eff = (int'(src_height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : src_height_q;
		size  = SZ_W'(w_eff) * SZ_W'(h_eff);
		wprod = WP_W'(w_eff) * WP_W'(factor_q);
		hprod = WP_W'(h_eff) * WP_W'(factor_q);
		ow_raw = wprod[DIM_W+FACT_W-1:FRAC_BITS];
		oh_raw = hprod[DIM_W+FACT_W-1:FRAC_BITS];
		ow_next = (ow_raw > {1'b0, COORD_MAX}) ? COORD_MAX : ow_raw[COORD_W-1:0];
		oh_next = (oh_raw > {1'b0, COORD_MAX}) ? COORD_MAX : oh_raw[COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q <= '0;
			oh_q <= '0;
		end else begin
			ow_q <= ow_next;
			oh_q <= oh_next;
		end
	end

	assign sts.empty = (ow_q == '0) || (oh_q == '0) || (factor_q == '0);

	assign pos_inc   = LW'(load_pos_q) + LW'(1);
	assign load_wrap = (size == '0) || (pos_inc >= LW'(size));

	assign coord_wrap = (col_q >= ow_q) || (row_q >= oh_q);
	assign col_eff    = coord_wrap ? '0 : col_q;
	assign row_eff    = coord_wrap ? '0 : row_q;
	assign is_last    = (col_q == ow_q - COORD_W'(1)) && (row_q == oh_q - COORD_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg_hit) begin
			load_pos_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else begin
			if (cmd.load_wr) begin
				load_pos_q <= load_wrap ? '0 : pos_inc[AW-1:0];
			end
			if (cmd.chk) begin
				col_q <= col_eff;
				row_q <= row_eff;
			end else if (cmd.advance) begin
				if ({1'b0, col_q} + (COORD_W+1)'(1) < {1'b0, ow_q}) begin
					col_q <= col_q + COORD_W'(1);
				end else begin
					col_q <= '0;
					row_q <= ({1'b0, row_q} + (COORD_W+1)'(1) < {1'b0, oh_q}) ?
						row_q + COORD_W'(1) : '0;
				end
			end
		end
	end

	assign dividend = cmd.div_row ? DIVD_W'({row_q, {FRAC_BITS{1'b0}}}) :
		DIVD_W'({col_eff, {FRAC_BITS{1'b0}}});

	nnis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (factor_q),
		.quotient (quotient),
		.done     (div_done)
	);

	assign sts.div_done = div_done;

	// Anything past the saturation point already lands outside the store
	assign quo_sat = (quotient > SAT_MAX) ? SAT_MAX[SAT_W-1:0] : quotient[SAT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.cap_x) begin
			sx_q <= quo_sat;
		end
		if (cmd.cap_y) begin
			sy_q <= quo_sat;
		end
		if (cmd.mul) begin
			prod_q <= PW'(sy_q) * PW'(w_eff);
		end
	end

	assign idx   = SW'(prod_q) + SW'(sx_q);
	assign raddr = (idx >= DEPTH_V) ? '0 : idx[AW-1:0];

	assign wdata = {in_data[3*CHAN_W +: CHANNEL_BITS], in_data[2*CHAN_W +: CHANNEL_BITS],
		in_data[CHAN_W +: CHANNEL_BITS], in_data[0 +: CHANNEL_BITS]};

	nnis_ram #(
		.WIDTH (MEM_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.load_wr),
		.waddr (load_pos_q),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			pix[k*CHAN_W +: CHAN_W] = CHAN_W'(rdata[k*CHANNEL_BITS +: CHANNEL_BITS]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_empty) begin
				out_data_q  <= '0;
				out_last_q  <= 1'b0;
				out_empty_q <= 1'b1;
			end else begin
				out_data_q  <= OUT_DATA_W'({row_q, col_q, pix});
				out_last_q  <= is_last;
				out_empty_q <= 1'b0;
			end
		end
	end

	assign out_data  = out_data_q;
	assign out_last  = out_last_q;
	assign out_empty = out_empty_q;

endmodule

FILE: rtl/core/nnis_ctrl.sv
`timescale 1ns / 1ps

module nnis_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_op,
	output logic              out_valid,
	input  logic              out_ready,
	input  nnis_pkg::dp_sts_t sts,
	output nnis_pkg::dp_cmd_t cmd
);

	import nnis_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHK   = 3'd1;
	localparam logic [2:0] S_DIVX  = 3'd2;
	localparam logic [2:0] S_DIVY  = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_ADR   = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;
	localparam logic [2:0] S_EMPTY = 3'd7;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       in_fire;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (in_op == OP_LOAD) begin
						cmd.load_wr = 1'b1;
					end else begin
						state_d = S_CHK;
					end
				end
			end
			S_CHK: begin
				if (sts.empty) begin
					state_d = S_EMPTY;
				end else begin
					cmd.chk       = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = S_DIVX;
				end
			end
			S_DIVX: begin
				if (sts.div_done) begin
					cmd.cap_x     = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_row   = 1'b1;
					state_d       = S_DIVY;
				end
			end
			S_DIVY: begin
				if (sts.div_done) begin
					cmd.cap_y = 1'b1;
					state_d   = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADR;
			end
			S_ADR: begin
				cmd.rd  = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					cmd.advance  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_EMPTY: begin
				if (slot_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_empty = 1'b1;
					state_d       = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/nearest_neighbor_image_scaler_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Contents
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: op; tdata: pixel to load
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: pixel, x, y; tlast; tuser: empty
// cfg       in         cfg_we (no wait)              cfg_addr: register, cfg_wdata: value
//
// A load writes the pixel straight into the frame store when it is accepted.
// A read steps through the check, x divide, y divide, multiply, address and emit
// states, with the shared divider producing both source coordinates at two quotient
// bits per cycle. An empty output image goes from the check state to the empty state,
// which loads the empty result; no new item is accepted until the state is back to idle.
// The frame store has no clearing pass; reset only clears control state.
// A result waiting on m_axis does not block loads; a second read stalls before
// the output register until the first result is taken.

module nearest_neighbor_image_scaler_core #(
	parameter int MAX_WIDTH    = 128,
	parameter int MAX_HEIGHT   = 128,
	parameter int CHANNEL_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port
	input  logic                            cfg_we,
	input  logic [nnis_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [nnis_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// Input items
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [nnis_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // in_hue, in_sat, in_lum, in_alpha
	input  logic [0:0]                      s_axis_tuser,  // op
	// Result items
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [nnis_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // out_hue, out_sat, out_lum,
	                                                        // out_alpha, out_x, out_y, pad
	output logic                            m_axis_tlast,  // last
	output logic [0:0]                      m_axis_tuser   // empty_res
);

	import nnis_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    out_empty;

	// Sequence one item at a time
	nnis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser[0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Config registers, frame store, coordinate divider, output register
	nnis_dp #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_empty (out_empty)
	);

	assign m_axis_tuser = out_empty;

endmodule

FILE: rtl/core/nnis_chk.sv
`timescale 1ns / 1ps

module nnis_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [0:0]                     s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [nnis_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tlast,
	input logic [0:0]                     m_axis_tuser
);

	import nnis_pkg::*;

	logic [1:0] pend_q;
	logic       rd_fire, out_fire;

	assign rd_fire  = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_READ);
	assign out_fire = m_axis_tvalid && m_axis_tready;

	// Reads accepted whose result has not been transferred yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (rd_fire && !out_fire) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_fire && !rd_fire) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tlast)
		else $error("empty result carries data");

	a_result_owed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 2'd0)
		else $error("result without a read");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many reads in flight");

endmodule

bind nearest_neighbor_image_scaler_core nnis_chk u_nnis_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
